// File: rtl/wit_pkg.sv
// Package for the 802.11 information-element parser.
// Holds the shared codes, field widths, element and attribute constants and the
// OUI table request and response types. It depends on nothing.
package wit_pkg;

  // Field widths of the stream items and the register.
  localparam int unsigned AREA_W  = 16;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned VALUE_W = 24;
  localparam int unsigned SLOT_W  = 3;
  localparam int unsigned COUNT_W = 15;

  // Default depth of the chipset OUI table.
  localparam int unsigned DEF_OUI_SLOTS = 8;

  // Element and attribute codes.
  localparam logic [BYTE_W-1:0]  IE_COUNTRY   = 8'h07;
  localparam logic [BYTE_W-1:0]  IE_VENDOR    = 8'hDD;
  localparam logic [23:0]        WPS_OUI      = 24'h0050F2;
  localparam logic [BYTE_W-1:0]  WPS_OUI_TYPE = 8'h04;
  localparam logic [15:0]        ATTR_MANUF   = 16'h1021;
  localparam logic [15:0]        ATTR_MODEL   = 16'h1023;
  localparam logic [15:0]        ATTR_MODELNO = 16'h1024;
  localparam logic [15:0]        ATTR_SERIAL  = 16'h1042;
  localparam logic [COUNT_W-1:0] COUNT_MAX    = 15'h7FFF;

  // Kinds of reported result.
  typedef enum logic [2:0] {
    KIND_NONE    = 3'd0,
    KIND_COUNTRY = 3'd1,
    KIND_MANUF   = 3'd2,
    KIND_MODEL   = 3'd3,
    KIND_SERIAL  = 3'd4,
    KIND_OUI     = 3'd5
  } kind_e;

  // Element-level parse phase.
  typedef enum logic [1:0] {
    PH_TYPE,
    PH_LEN,
    PH_BODY,
    PH_STOP
  } phase_e;

  // WPS attribute sub-parse mode inside a vendor element.
  typedef enum logic [1:0] {
    WPS_OFF,
    WPS_HDR,
    WPS_DATA,
    WPS_SKIP
  } wps_e;

  // Request from the parser to the OUI table.
  typedef struct packed {
    logic        clear;
    logic        insert;
    logic [23:0] oui;
  } oui_req_t;

  // Response of the OUI table in the same cycle.
  typedef struct packed {
    logic              stored;
    logic [SLOT_W-1:0] slot;
  } oui_rsp_t;

endpackage

// File: rtl/wit_in_if.sv
// Input channel of the element parser: one area byte per item.
// Depends on wit_pkg for the field widths.
interface wit_in_if import wit_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              first_of_buffer;

  modport source (output valid, output data_byte, output first_of_buffer, input ready);
  modport sink   (input valid, input data_byte, input first_of_buffer, output ready);
endinterface

// File: rtl/wit_out_if.sv
// Result channel of the element parser: one report per item.
// Depends on wit_pkg for the field widths and the kind codes.
interface wit_out_if import wit_pkg::*; ();
  logic               valid;
  logic               ready;
  kind_e              kind;
  logic [VALUE_W-1:0] value;
  logic               has_byte;
  logic               string_start;
  logic [SLOT_W-1:0]  oui_slot;
  logic               done_res;
  logic               truncated;
  logic [COUNT_W-1:0] element_count;

  modport source (output valid, output kind, output value, output has_byte,
                  output string_start, output oui_slot, output done_res,
                  output truncated, output element_count, input ready);
  modport sink   (input valid, input kind, input value, input has_byte,
                  input string_start, input oui_slot, input done_res,
                  input truncated, input element_count, output ready);
endinterface

// File: rtl/wit_oui_table.sv
// Deduplicating chipset OUI table with a fill count.
// Compares a new OUI against all filled slots in parallel and stores it if new and the table is not full.
// Depends on wit_pkg for the request and response types.
module wit_oui_table import wit_pkg::*; #(
  parameter int unsigned OUI_SLOTS = DEF_OUI_SLOTS
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  oui_req_t req_i,
  output oui_rsp_t rsp_o
);

  localparam int unsigned CNT_W = $clog2(OUI_SLOTS + 1);
  localparam int unsigned IDX_W = (OUI_SLOTS > 1) ? $clog2(OUI_SLOTS) : 1;

  logic [23:0]      table_q [OUI_SLOTS];
  logic [CNT_W-1:0] used_q, used_d;
  logic [CNT_W-1:0] used_cur;
  logic             hit;
  logic             full;
  logic             stored;

  // A buffer start empties the table before the lookup.
  assign used_cur = req_i.clear ? '0 : used_q;

  // Parallel compare against the filled slots only.
  always_comb begin
    hit = 1'b0;
    for (int i = 0; i < OUI_SLOTS; i++) begin
      if ((CNT_W'(i) < used_cur) && (table_q[i] == req_i.oui)) begin
        hit = 1'b1;
      end
    end
  end

  assign full     = (used_cur == CNT_W'(OUI_SLOTS));
  assign stored   = req_i.insert && !hit && !full;
  assign used_d   = stored ? used_cur + CNT_W'(1) : used_cur;

  // The reported slot keeps only the low bits of the slot number.
  assign rsp_o.stored = stored;
  assign rsp_o.slot   = SLOT_W'(used_cur);

  // Fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else begin
      used_q <= used_d;
    end
  end

  // Slot storage; validity comes from the fill count.
  always_ff @(posedge clk_i) begin
    if (stored) begin
      table_q[used_cur[IDX_W-1:0]] <= req_i.oui;
    end
  end

endmodule

// File: rtl/wlan_ie_tlv_parser.sv
// Top level of the streaming 802.11 information-element parser.
// Depends on wit_pkg, the wit_in_if and wit_out_if channels and wit_oui_table.
//
// The block takes one byte of a beacon's element area per item and sustains one item
// per clock cycle while results are taken. Each byte passes an input register, the
// combinational parse logic with the parallel compare of the OUI table, and a result
// register. The whole parse state and the OUI table are updated in the same cycle as
// the result register is loaded. A result that waits on out_o.ready holds the byte
// behind it in the input register, and input stops until the result is taken. A byte
// that yields no report and is not the last of the area gives no result.
// Write ie_area_bytes through cfg_we_i/cfg_data_i before the buffer's first byte,
// which is marked with first_of_buffer.
module wlan_ie_tlv_parser import wit_pkg::*; #(
  parameter int unsigned OUI_SLOTS = DEF_OUI_SLOTS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [AREA_W-1:0] cfg_data_i,
  wit_in_if.sink            in_i,
  wit_out_if.source         out_o
);

  // Configuration register.
  logic [AREA_W-1:0] area_q;

  // Input register.
  logic              inv_q;
  logic [BYTE_W-1:0] byte_q;
  logic              first_q;

  // Parse state.
  logic [AREA_W-1:0]  pos_q, pos_d, pos_cur;
  phase_e             phase_q, phase_d, phase_cur;
  logic [BYTE_W-1:0]  etype_q, etype_d, etype_cur;
  logic [BYTE_W-1:0]  eleft_q, eleft_d, eleft_cur;
  logic [BYTE_W-1:0]  bidx_q, bidx_d, bidx_cur;
  logic [23:0]        hdr_q, hdr_d, hdr_cur;
  logic [1:0]         hcnt_q, hcnt_d, hcnt_cur;
  logic [BYTE_W-1:0]  aleft_q, aleft_d, aleft_cur;
  logic [23:0]        prefix_q, prefix_d, prefix_cur;
  wps_e               wps_q, wps_d, wps_cur;
  kind_e              akind_q, akind_d, akind_cur;
  logic               afirst_q, afirst_d, afirst_cur;
  logic               model_q, model_d, model_cur;
  logic [COUNT_W-1:0] count_q, count_d, count_cur;
  logic               stopped_q, stopped_d, stopped_cur;

  // Result register.
  logic               outv_q;
  kind_e              rkind_q;
  logic [VALUE_W-1:0] rvalue_q;
  logic               rhas_q;
  logic               rstart_q;
  logic [SLOT_W-1:0]  rslot_q;
  logic               rdone_q;
  logic               rtrunc_q;
  logic [COUNT_W-1:0] rcount_q;

  // Per-byte decode.
  logic               adv;
  logic               clr;
  logic               act;
  logic               done;
  logic               emit;
  logic [AREA_W-1:0]  rem_area;
  logic [AREA_W-1:0]  left_after;
  logic [8:0]         body_size;
  logic [15:0]        attr_id;
  logic [15:0]        attr_sz;
  logic               body_last;
  kind_e              p_kind;
  logic [VALUE_W-1:0] p_value;
  logic               p_has;
  logic               p_start;
  kind_e              r_kind;
  logic [VALUE_W-1:0] r_value;
  logic [SLOT_W-1:0]  r_slot;
  oui_req_t           oui_req;
  oui_rsp_t           oui_rsp;

  // Handshake: a byte advances when the result register has room.
  assign adv        = inv_q && (!outv_q || out_o.ready);
  assign in_i.ready = !inv_q || adv;
  assign clr        = adv && first_q;

  // State as seen by this byte, after an optional buffer start.
  assign pos_cur     = first_q ? '0 : pos_q;
  assign phase_cur   = first_q ? PH_TYPE : phase_q;
  assign etype_cur   = first_q ? '0 : etype_q;
  assign eleft_cur   = first_q ? '0 : eleft_q;
  assign bidx_cur    = first_q ? '0 : bidx_q;
  assign hdr_cur     = first_q ? '0 : hdr_q;
  assign hcnt_cur    = first_q ? '0 : hcnt_q;
  assign aleft_cur   = first_q ? '0 : aleft_q;
  assign prefix_cur  = first_q ? '0 : prefix_q;
  assign wps_cur     = first_q ? WPS_OFF : wps_q;
  assign akind_cur   = first_q ? KIND_NONE : akind_q;
  assign afirst_cur  = first_q ? 1'b0 : afirst_q;
  assign model_cur   = first_q ? 1'b0 : model_q;
  assign count_cur   = first_q ? '0 : count_q;
  assign stopped_cur = first_q ? 1'b0 : stopped_q;

  // Position decode within the configured area.
  assign act        = adv && (pos_cur < area_q);
  assign done       = act && (({1'b0, pos_cur} + 17'd1) == {1'b0, area_q});
  assign rem_area   = area_q - pos_cur;
  assign left_after = rem_area - AREA_W'(1);
  assign body_size  = {1'b0, bidx_cur} + {1'b0, eleft_cur};
  assign attr_id    = hdr_cur[23:8];
  assign attr_sz    = {hdr_cur[7:0], byte_q};
  assign body_last  = (eleft_cur == BYTE_W'(1));

  // Element phase sequencing.
  always_comb begin
    phase_d = phase_cur;
    if (act) begin
      unique case (phase_cur)
        PH_TYPE: begin
          if (rem_area >= AREA_W'(2)) begin
            phase_d = PH_LEN;
          end
        end
        PH_LEN: begin
          if ({8'd0, byte_q} > left_after) begin
            phase_d = PH_STOP;
          end else if (byte_q == '0) begin
            phase_d = PH_TYPE;
          end else begin
            phase_d = PH_BODY;
          end
        end
        PH_BODY: begin
          if (body_last) begin
            phase_d = PH_TYPE;
          end
        end
        PH_STOP: phase_d = PH_STOP;
        default: phase_d = PH_TYPE;
      endcase
    end
  end

  // Element headers, body bytes and the WPS attribute walk.
  always_comb begin
    pos_d      = pos_cur;
    etype_d    = etype_cur;
    eleft_d    = eleft_cur;
    bidx_d     = bidx_cur;
    hdr_d      = hdr_cur;
    hcnt_d     = hcnt_cur;
    aleft_d    = aleft_cur;
    prefix_d   = prefix_cur;
    wps_d      = wps_cur;
    akind_d    = akind_cur;
    afirst_d   = afirst_cur;
    model_d    = model_cur;
    count_d    = count_cur;
    stopped_d  = stopped_cur;
    p_kind     = KIND_NONE;
    p_value    = '0;
    p_has      = 1'b0;
    p_start    = 1'b0;
    oui_req.clear  = clr;
    oui_req.insert = 1'b0;
    oui_req.oui    = {prefix_cur[15:0], byte_q};
    if (act) begin
      pos_d = pos_cur + AREA_W'(1);
      unique case (phase_cur)
        PH_TYPE: begin
          if (rem_area >= AREA_W'(2)) begin
            etype_d = byte_q;
          end
        end
        PH_LEN: begin
          if ({8'd0, byte_q} > left_after) begin
            stopped_d = 1'b1;
          end else begin
            if (count_cur != COUNT_MAX) begin
              count_d = count_cur + COUNT_W'(1);
            end
            eleft_d  = byte_q;
            bidx_d   = '0;
            wps_d    = WPS_OFF;
            hcnt_d   = '0;
            prefix_d = '0;
          end
        end
        PH_BODY: begin
          bidx_d  = bidx_cur + BYTE_W'(1);
          eleft_d = eleft_cur - BYTE_W'(1);
          if (etype_cur == IE_COUNTRY) begin
            // Country: report the first two characters of a body of three or more.
            if (body_size >= 9'd3) begin
              if (bidx_cur == 8'd0) begin
                prefix_d = {16'd0, byte_q};
              end else if (bidx_cur == 8'd1) begin
                p_kind  = KIND_COUNTRY;
                p_value = {8'd0, prefix_cur[7:0], byte_q};
              end
            end
          end else if (etype_cur == IE_VENDOR) begin
            if (bidx_cur < 8'd4) begin
              // Vendor prefix: OUI, then the OUI type byte.
              prefix_d = {prefix_cur[15:0], byte_q};
              if (bidx_cur == 8'd2) begin
                oui_req.insert = ({prefix_cur[15:0], byte_q} != WPS_OUI);
              end else if (bidx_cur == 8'd3) begin
                if ((prefix_cur == WPS_OUI) && (byte_q == WPS_OUI_TYPE)) begin
                  wps_d  = WPS_HDR;
                  hcnt_d = '0;
                  hdr_d  = '0;
                end
              end
            end else begin
              case (wps_cur)
                WPS_HDR: begin
                  if ((hcnt_cur == 2'd0) && (eleft_cur < 8'd4)) begin
                    wps_d = WPS_SKIP;
                  end else begin
                    hdr_d  = {hdr_cur[15:0], byte_q};
                    hcnt_d = hcnt_cur + 2'd1;
                    if (hcnt_cur == 2'd3) begin
                      // Full attribute header: id and size, both big-endian.
                      hcnt_d = '0;
                      if (attr_sz > {8'd0, eleft_cur - BYTE_W'(1)}) begin
                        wps_d = WPS_SKIP;
                      end else begin
                        akind_d = KIND_NONE;
                        if (attr_id == ATTR_MANUF) begin
                          akind_d = KIND_MANUF;
                        end else if (attr_id == ATTR_MODEL) begin
                          if (!model_cur) begin
                            akind_d = KIND_MODEL;
                            model_d = 1'b1;
                          end
                        end else if (attr_id == ATTR_MODELNO) begin
                          akind_d = KIND_MODEL;
                          model_d = 1'b1;
                        end else if (attr_id == ATTR_SERIAL) begin
                          akind_d = KIND_SERIAL;
                        end
                        aleft_d = attr_sz[7:0];
                        if (attr_sz == 16'd0) begin
                          // Empty string: report only its start.
                          if (akind_d != KIND_NONE) begin
                            p_kind  = akind_d;
                            p_start = 1'b1;
                          end
                        end else begin
                          wps_d    = WPS_DATA;
                          afirst_d = 1'b1;
                        end
                      end
                    end
                  end
                end
                WPS_DATA: begin
                  if (akind_cur != KIND_NONE) begin
                    p_kind  = akind_cur;
                    p_value = {16'd0, byte_q};
                    p_has   = 1'b1;
                    p_start = afirst_cur;
                  end
                  afirst_d = 1'b0;
                  aleft_d  = aleft_cur - BYTE_W'(1);
                  if (aleft_cur == BYTE_W'(1)) begin
                    wps_d  = WPS_HDR;
                    hcnt_d = '0;
                  end
                end
                default: begin
                end
              endcase
            end
          end
        end
        PH_STOP: begin
        end
        default: begin
        end
      endcase
    end
  end

  wit_oui_table #(
    .OUI_SLOTS (OUI_SLOTS)
  ) u_oui_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (oui_req),
    .rsp_o  (oui_rsp)
  );

  // Merge the OUI table report with the parse report.
  always_comb begin
    r_kind  = p_kind;
    r_value = p_value;
    r_slot  = '0;
    if (oui_rsp.stored) begin
      r_kind  = KIND_OUI;
      r_value = oui_req.oui;
      r_slot  = oui_rsp.slot;
    end
  end

  assign emit = act && ((r_kind != KIND_NONE) || done);

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      area_q <= '0;
    end else if (cfg_we_i) begin
      area_q <= cfg_data_i;
    end
  end

  // Input register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_q <= 1'b0;
    end else if (in_i.ready) begin
      inv_q <= in_i.valid;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      byte_q  <= in_i.data_byte;
      first_q <= in_i.first_of_buffer;
    end
  end

  // Parse state, updated once per advanced item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      phase_q   <= PH_TYPE;
      etype_q   <= '0;
      eleft_q   <= '0;
      bidx_q    <= '0;
      hdr_q     <= '0;
      hcnt_q    <= '0;
      aleft_q   <= '0;
      prefix_q  <= '0;
      wps_q     <= WPS_OFF;
      akind_q   <= KIND_NONE;
      afirst_q  <= 1'b0;
      model_q   <= 1'b0;
      count_q   <= '0;
      stopped_q <= 1'b0;
    end else if (adv) begin
      pos_q     <= pos_d;
      phase_q   <= phase_d;
      etype_q   <= etype_d;
      eleft_q   <= eleft_d;
      bidx_q    <= bidx_d;
      hdr_q     <= hdr_d;
      hcnt_q    <= hcnt_d;
      aleft_q   <= aleft_d;
      prefix_q  <= prefix_d;
      wps_q     <= wps_d;
      akind_q   <= akind_d;
      afirst_q  <= afirst_d;
      model_q   <= model_d;
      count_q   <= count_d;
      stopped_q <= stopped_d;
    end
  end

  // Result register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outv_q <= 1'b0;
    end else if (adv) begin
      outv_q <= emit;
    end else if (out_o.ready) begin
      outv_q <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      rkind_q  <= r_kind;
      rvalue_q <= r_value;
      rhas_q   <= p_has;
      rstart_q <= p_start;
      rslot_q  <= r_slot;
      rdone_q  <= done;
      rtrunc_q <= stopped_d;
      rcount_q <= count_d;
    end
  end

  assign out_o.valid         = outv_q;
  assign out_o.kind          = rkind_q;
  assign out_o.value         = rvalue_q;
  assign out_o.has_byte      = rhas_q;
  assign out_o.string_start  = rstart_q;
  assign out_o.oui_slot      = rslot_q;
  assign out_o.done_res      = rdone_q;
  assign out_o.truncated     = rtrunc_q;
  assign out_o.element_count = rcount_q;

endmodule
